// ----- hw/rtl/pkcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcd_pkg - shared types and functions for the packet CRC-8 check deframer
// Holds the result beat layout, the CRC-8 byte update and the default
// packet length.
// ----------------------------------------------------------------------------
package pkcd_pkg;

	localparam int unsigned PKT_BYTES_DEF = 128;

	// Reflected CRC-8 feedback: xor 0x18, shift right, set the top bit.
	localparam logic [7:0] CRC_FEEDBACK = 8'h18;
	localparam logic [7:0] CRC_TOP_BIT  = 8'h80;

	// Output beat width: 33 payload bits padded to whole bytes.
	localparam int unsigned OUT_BITS  = 33;
	localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;
	localparam int unsigned OUT_W     = OUT_BYTES * 8;

	typedef struct packed {
		logic [7:0] payload_size;
		logic [5:0] seq_or_ack;
		logic       is_end;
		logic       is_ack;
		logic       crc_ok;
		logic [7:0] byte_index;
		logic [7:0] pass_byte;
	} result_t;

	typedef struct packed {
		result_t res;
		logic    packet_done;
	} beat_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
	                                           input logic [7:0] data_in);
		logic [7:0] crc;
		logic [7:0] data;
		crc  = crc_in;
		data = data_in;
		for (int i = 0; i < 8; i++) begin
			if (crc[0] ^ data[0]) begin
				crc = ((crc ^ CRC_FEEDBACK) >> 1) | CRC_TOP_BIT;
			end else begin
				crc = crc >> 1;
			end
			data = data >> 1;
		end
		return crc;
	endfunction

endpackage

// ----- hw/rtl/pkcd_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcd_core - packet state and per-byte result logic
// Tracks the byte index, running CRC and captured header and size bytes,
// and forms the result beat for each accepted byte.
// ----------------------------------------------------------------------------
module pkcd_core #(
	parameter int unsigned PKT_BYTES = pkcd_pkg::PKT_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      rx_byte,
	output pkcd_pkg::beat_t beat
);
	import pkcd_pkg::*;

	localparam logic [7:0] LAST_INDEX = 8'((PKT_BYTES - 1) % 256);

	logic [7:0] crc_q;
	logic [7:0] count_q;
	logic [7:0] header_q;
	logic [7:0] size_q;

	logic [7:0] crc_next;
	logic       last;

	assign crc_next = crc8_update(crc_q, rx_byte);
	assign last     = (count_q == LAST_INDEX);

	always_comb begin
		beat                  = '0;
		beat.res.pass_byte    = rx_byte;
		beat.res.byte_index   = count_q;
		beat.packet_done      = last;
		if (last) begin
			beat.res.crc_ok       = (crc_next == 8'h00);
			beat.res.is_ack       = header_q[0];
			beat.res.is_end       = header_q[1];
			beat.res.seq_or_ack   = header_q[7:2];
			beat.res.payload_size = size_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= '0;
			count_q  <= '0;
			header_q <= '0;
			size_q   <= '0;
		end else if (take) begin
			if (count_q == 8'd0) begin
				header_q <= rx_byte;
			end
			if (count_q == 8'd1) begin
				size_q <= rx_byte;
			end
			if (last) begin
				crc_q   <= '0;
				count_q <= '0;
			end else begin
				crc_q   <= crc_next;
				count_q <= count_q + 8'd1;
			end
		end
	end

endmodule

// ----- hw/rtl/pkcd_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcd_out_buf - output register with skid stage
// Holds result beats so the input side can pass one more beat into the skid
// register when the master side stalls.
// ----------------------------------------------------------------------------
module pkcd_out_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  pkcd_pkg::beat_t in_beat,
	output logic            out_valid,
	input  logic            out_ready,
	output pkcd_pkg::beat_t out_beat
);
	import pkcd_pkg::*;

	beat_t main_q;
	beat_t skid_q;
	logic  main_valid_q;
	logic  skid_valid_q;

	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_beat  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_ready || !main_valid_q) begin
				// advance: skid first, else the incoming beat
				if (skid_valid_q) begin
					main_valid_q <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					main_valid_q <= in_valid;
				end
			end else if (in_valid && in_ready) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !main_valid_q) begin
			main_q <= skid_valid_q ? skid_q : in_beat;
		end else if (in_valid && in_ready) begin
			skid_q <= in_beat;
		end
	end

endmodule

// ----- hw/rtl/packet_crc8_check_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_crc8_check_deframer - fixed-length packet receiver with CRC-8 check
// Passes every received byte through with its index and, on the last byte
// of each packet, reports the reflected CRC-8 check and the header fields.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side (s_tvalid/s_tready/s_tdata) takes one packet byte per beat,
//   in transmission order; packets are PKT_BYTES beats long, the last beat
//   carrying the transmitted CRC. Byte 0 is the header, byte 1 the payload
//   size.
//   Master side (m_tvalid/m_tready/m_tdata/m_tlast) gives one result beat per
//   input beat. m_tlast marks the last byte of a packet; only then are
//   crc_ok and the header fields meaningful, otherwise they read zero.
//   Each accepted byte's result is registered (main or skid register) before
//   it reaches the master side. Throughput: one byte per cycle while m_tready
//   is high, set by the byte-wide CRC update before the result register.
//   Stall: when m_tready drops, one more beat is held in a skid stage, then
//   s_tready drops until the master side drains. No beat is lost.
//   Reset (arst_n low): drops any held beats, clears the running CRC, the
//   byte index and the captured header and size bytes; the next byte
//   starts a new packet.
// ----------------------------------------------------------------------------
module packet_crc8_check_deframer #(
	parameter int unsigned PKT_BYTES = pkcd_pkg::PKT_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // [7:0] rx_byte
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [7:0] pass_byte, [15:8] byte_index, [16] crc_ok, [17] is_ack,
	// [18] is_end, [24:19] seq_or_ack, [32:25] payload_size, rest zero
	output logic [pkcd_pkg::OUT_W-1:0] m_tdata,
	output logic                        m_tlast   // packet_done
);
	import pkcd_pkg::*;

	beat_t core_beat;
	beat_t out_beat;
	logic  take;

	// accept a byte on the slave handshake; state advances in the same edge
	assign take = s_tvalid && s_tready;

	pkcd_core #(
		.PKT_BYTES(PKT_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (s_tdata),
		.beat    (core_beat)
	);

	pkcd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_beat   (core_beat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_beat  (out_beat)
	);

	// pad the packed result up to whole bytes
	assign m_tdata = OUT_W'(out_beat.res);
	assign m_tlast = out_beat.packet_done;

endmodule
